/* hdl/tgmc_pkg.sv */
// ----------------------------------------------------------------------------
// tgmc_pkg: shared types and constants of the transition group merge counter
// Field widths, default sizes, the key table entry and the sequencer states.
// ----------------------------------------------------------------------------
package tgmc_pkg;

    // Field widths fixed by the interface.
    localparam int CNT_W   = 9;
    localparam int TGT_W   = 16;
    localparam int MARK_W  = 32;
    localparam int SAVED_W = 8;
    localparam int LIMIT_W = 9;

    // Group limit after reset.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd3;

    // Default sizes of the row and of the distinct-key table.
    localparam int ROW_LENGTH_DEF = 256;
    localparam int KEY_SLOTS_DEF  = 256;

    // One entry of the distinct-key table.
    typedef struct packed {
        logic [TGT_W-1:0]  target;
        logic [MARK_W-1:0] marker;
        logic [CNT_W-1:0]  fill;
    } t_key_entry;

    // Strobes from the sequencer to the key table.
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_UPDATE,
        S_FINISH
    } t_state;

endpackage

/* hdl/tgmc_key_mem.sv */
// ----------------------------------------------------------------------------
// tgmc_key_mem: distinct-key table
// Single-port write, single-port read memory with registered read data.
// ----------------------------------------------------------------------------
module tgmc_key_mem #(
    parameter int KEY_SLOTS = tgmc_pkg::KEY_SLOTS_DEF,
    localparam int SLOT_W   = $clog2(KEY_SLOTS)
) (
    input  logic                 i_clk,
    input  tgmc_pkg::t_mem_ctl   i_ctl,
    input  logic [SLOT_W-1:0]    i_waddr,
    input  tgmc_pkg::t_key_entry i_wdata,
    input  logic [SLOT_W-1:0]    i_raddr,
    output tgmc_pkg::t_key_entry o_rdata
);

    tgmc_pkg::t_key_entry r_mem [KEY_SLOTS];
    tgmc_pkg::t_key_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/tgmc_ctrl.sv */
// ----------------------------------------------------------------------------
// tgmc_ctrl: search and count sequencer
// Walks the key table one slot at a time through a shared key comparator
// and keeps the per-row transition, key and group counts.
// ----------------------------------------------------------------------------
module tgmc_ctrl #(
    parameter int ROW_LENGTH = tgmc_pkg::ROW_LENGTH_DEF,
    parameter int KEY_SLOTS  = tgmc_pkg::KEY_SLOTS_DEF,
    localparam int SLOT_W    = $clog2(KEY_SLOTS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_has_transition,
    input  logic [tgmc_pkg::TGT_W-1:0]    i_target_state,
    input  logic [tgmc_pkg::MARK_W-1:0]   i_marker_offset,
    input  logic                          i_row_end,
    input  logic [tgmc_pkg::LIMIT_W-1:0]  i_group_limit,
    output tgmc_pkg::t_mem_ctl            o_mem_ctl,
    output logic [SLOT_W-1:0]             o_mem_waddr,
    output tgmc_pkg::t_key_entry          o_mem_wdata,
    output logic [SLOT_W-1:0]             o_mem_raddr,
    input  tgmc_pkg::t_key_entry          i_mem_rdata,
    input  logic                          i_res_free,
    output logic                          o_res_load,
    output logic [tgmc_pkg::CNT_W-1:0]    o_res_present,
    output logic [tgmc_pkg::CNT_W-1:0]    o_res_groups
);

    localparam logic [tgmc_pkg::CNT_W-1:0] ROW_MAX   = tgmc_pkg::CNT_W'(ROW_LENGTH);
    localparam logic [tgmc_pkg::CNT_W-1:0] SLOTS_MAX = tgmc_pkg::CNT_W'(KEY_SLOTS);

    tgmc_pkg::t_state r_state, n_state;

    logic                          r_has;
    logic [tgmc_pkg::TGT_W-1:0]    r_tgt;
    logic [tgmc_pkg::MARK_W-1:0]   r_mark;
    logic                          r_last;
    logic [SLOT_W-1:0]             r_idx;
    logic [tgmc_pkg::CNT_W-1:0]    r_fill_old;
    logic                          r_new;
    logic [tgmc_pkg::CNT_W-1:0]    r_keys;
    logic [tgmc_pkg::CNT_W-1:0]    r_present;
    logic [tgmc_pkg::CNT_W-1:0]    r_groups;

    logic                          accept;
    logic                          take;
    logic                          hit;
    logic                          last_slot;
    logic                          table_full;
    logic [tgmc_pkg::CNT_W-1:0]    limit;
    logic [tgmc_pkg::CNT_W-1:0]    fill_inc;
    logic [tgmc_pkg::CNT_W-1:0]    fill_next;

    assign accept     = i_in_valid && (r_state == tgmc_pkg::S_IDLE);
    // A present entry is only counted while the row has room.
    assign take       = i_has_transition && (r_present < ROW_MAX);
    assign hit        = (i_mem_rdata.target == r_tgt) && (i_mem_rdata.marker == r_mark);
    assign last_slot  = (tgmc_pkg::CNT_W'(r_idx) + tgmc_pkg::CNT_W'(1)) == r_keys;
    assign table_full = r_new && (r_keys >= SLOTS_MAX);
    // A group limit of zero acts as one.
    assign limit      = (i_group_limit == '0) ? tgmc_pkg::CNT_W'(1) : i_group_limit;
    assign fill_inc   = r_fill_old + tgmc_pkg::CNT_W'(1);
    assign fill_next  = (fill_inc >= limit) ? '0 : fill_inc;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tgmc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (take && (r_keys == '0)) begin
                        n_state = tgmc_pkg::S_UPDATE;
                    end else if (take) begin
                        n_state = tgmc_pkg::S_READ;
                    end else begin
                        n_state = tgmc_pkg::S_FINISH;
                    end
                end
            end
            tgmc_pkg::S_READ: begin
                n_state = tgmc_pkg::S_CMP;
            end
            tgmc_pkg::S_CMP: begin
                if (hit || last_slot) begin
                    n_state = tgmc_pkg::S_UPDATE;
                end else begin
                    n_state = tgmc_pkg::S_READ;
                end
            end
            tgmc_pkg::S_UPDATE: begin
                n_state = tgmc_pkg::S_FINISH;
            end
            tgmc_pkg::S_FINISH: begin
                if (!r_last || i_res_free) begin
                    n_state = tgmc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tgmc_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_stall       = 1'b1;
        o_mem_ctl.we     = 1'b0;
        o_mem_ctl.re     = 1'b0;
        o_res_load       = 1'b0;
        case (r_state)
            tgmc_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
            end
            tgmc_pkg::S_READ: begin
                o_mem_ctl.re = 1'b1;
            end
            tgmc_pkg::S_CMP: begin
                o_mem_ctl.re = 1'b0;
            end
            tgmc_pkg::S_UPDATE: begin
                o_mem_ctl.we = !table_full;
            end
            tgmc_pkg::S_FINISH: begin
                o_res_load = r_last && i_res_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign o_mem_raddr        = r_idx;
    assign o_mem_waddr        = r_new ? r_keys[SLOT_W-1:0] : r_idx;
    assign o_mem_wdata.target = r_tgt;
    assign o_mem_wdata.marker = r_mark;
    assign o_mem_wdata.fill   = fill_next;
    assign o_res_present      = r_present;
    assign o_res_groups       = r_groups;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tgmc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Item latch and search pointer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_has      <= i_has_transition;
            r_tgt      <= i_target_state;
            r_mark     <= i_marker_offset;
            r_last     <= i_row_end;
            r_idx      <= '0;
            r_new      <= 1'b1;
            r_fill_old <= '0;
        end else if (r_state == tgmc_pkg::S_CMP) begin
            if (hit) begin
                r_new      <= 1'b0;
                r_fill_old <= i_mem_rdata.fill;
            end else if (!last_slot) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
        end
    end

    // Row counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys    <= '0;
            r_present <= '0;
            r_groups  <= '0;
        end else begin
            if (accept && take) begin
                r_present <= r_present + tgmc_pkg::CNT_W'(1);
            end
            if (r_state == tgmc_pkg::S_UPDATE) begin
                if (table_full || (r_fill_old == '0)) begin
                    r_groups <= r_groups + tgmc_pkg::CNT_W'(1);
                end
                if (r_new && !table_full) begin
                    r_keys <= r_keys + tgmc_pkg::CNT_W'(1);
                end
            end
            if (o_res_load) begin
                r_keys    <= '0;
                r_present <= '0;
                r_groups  <= '0;
            end
        end
    end

    a_keys_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_keys <= SLOTS_MAX)
        else $error("key count exceeds the table size");

    a_groups_le_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_groups <= r_present)
        else $error("more groups than transitions");

    a_present_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_present <= ROW_MAX)
        else $error("transition count exceeds the row length");

    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tgmc_pkg::S_CMP) |-> ($past(r_state) == tgmc_pkg::S_READ))
        else $error("compare without a table read");

    a_search_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tgmc_pkg::S_READ) |-> (r_has && (r_keys != '0)))
        else $error("table search without a present entry");

endmodule

/* hdl/transition_group_merge_counter_core.sv */
// ----------------------------------------------------------------------------
// transition_group_merge_counter_core: greedy rule merge counter
// Counts present transitions and greedily merged groups of one row.
// ----------------------------------------------------------------------------
// Sequence: an absent entry, or one past the row length, goes from S_IDLE to
// S_FINISH; a present entry searches the table first, S_READ then S_CMP per slot
// (its key's slot plus one, or all stored keys for a new key, up to KEY_SLOTS),
// then passes S_UPDATE. The input stalls outside S_IDLE: no new entry is taken
// before the last is through. A row end also waits while a summary is held.
// Reset (synchronous) zeroes the row counts, sets the limit to 3, keeps the table.
// ----------------------------------------------------------------------------
module transition_group_merge_counter_core #(
    parameter int ROW_LENGTH = tgmc_pkg::ROW_LENGTH_DEF,
    parameter int KEY_SLOTS  = tgmc_pkg::KEY_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration: the group limit register.
    input  logic                          i_cfg_we,
    input  logic [tgmc_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    // Input channel: one character entry per transfer.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_has_transition,
    input  logic [tgmc_pkg::TGT_W-1:0]    i_target_state,
    input  logic [tgmc_pkg::MARK_W-1:0]   i_marker_offset,
    input  logic                          i_row_end,
    // Output channel: one row summary per transfer.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tgmc_pkg::CNT_W-1:0]    o_transition_total,
    output logic [tgmc_pkg::CNT_W-1:0]    o_group_total,
    output logic [tgmc_pkg::SAVED_W-1:0]  o_rules_saved
);

    localparam int SLOT_W = $clog2(KEY_SLOTS);

    // Configured group limit.
    logic [tgmc_pkg::LIMIT_W-1:0] r_group_limit;

    // Key table connections.
    tgmc_pkg::t_mem_ctl    mem_ctl;
    logic [SLOT_W-1:0]     mem_waddr;
    logic [SLOT_W-1:0]     mem_raddr;
    tgmc_pkg::t_key_entry  mem_wdata;
    tgmc_pkg::t_key_entry  mem_rdata;

    // Result handoff from the sequencer into the output register.
    logic                          res_free;
    logic                          res_load;
    logic [tgmc_pkg::CNT_W-1:0]    res_present;
    logic [tgmc_pkg::CNT_W-1:0]    res_groups;

    // Output register.
    logic                          r_out_valid;
    logic [tgmc_pkg::CNT_W-1:0]    r_transition_total;
    logic [tgmc_pkg::CNT_W-1:0]    r_group_total;
    logic [tgmc_pkg::SAVED_W-1:0]  r_rules_saved;
    logic [tgmc_pkg::CNT_W-1:0]    saved_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_limit <= tgmc_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_group_limit <= i_cfg_wdata;
        end
    end

    tgmc_key_mem #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_key_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tgmc_ctrl #(
        .ROW_LENGTH (ROW_LENGTH),
        .KEY_SLOTS  (KEY_SLOTS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_has_transition (i_has_transition),
        .i_target_state   (i_target_state),
        .i_marker_offset  (i_marker_offset),
        .i_row_end        (i_row_end),
        .i_group_limit    (r_group_limit),
        .o_mem_ctl        (mem_ctl),
        .o_mem_waddr      (mem_waddr),
        .o_mem_wdata      (mem_wdata),
        .o_mem_raddr      (mem_raddr),
        .i_mem_rdata      (mem_rdata),
        .i_res_free       (res_free),
        .o_res_load       (res_load),
        .o_res_present    (res_present),
        .o_res_groups     (res_groups)
    );

    // The output register can take a new summary when it is empty or when its
    // current summary is transferred in this cycle.
    assign res_free   = !r_out_valid || !i_out_stall;
    // Every group holds at least one transition, so the difference never
    // goes negative; the saved count fits in eight bits.
    assign saved_full = res_present - res_groups;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_transition_total <= res_present;
            r_group_total      <= res_groups;
            r_rules_saved      <= saved_full[tgmc_pkg::SAVED_W-1:0];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_transition_total = r_transition_total;
    assign o_group_total      = r_group_total;
    assign o_rules_saved      = r_rules_saved;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> res_free)
        else $error("summary loaded over one not yet transferred");

    a_summary_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_group_total <= r_transition_total))
        else $error("summary reports more groups than transitions");

    a_limit_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_group_limit == tgmc_pkg::LIMIT_RESET) || $past(i_cfg_we))
        else $error("group limit not restored by reset");

endmodule

/* tb/sv/tb_transition_group_merge_counter_core.sv */
// ----------------------------------------------------------------------------
// tb_transition_group_merge_counter_core: self-checking bench of the merge counter
// Feeds transition rows one character entry per transfer and predicts every row
// summary with a behavioral copy of the greedy grouping. A short table of
// directed rows comes first, followed by random rows under several group limits.
// Both channels idle in random bursts, and each summary is checked field by field.
// ----------------------------------------------------------------------------
module tb_transition_group_merge_counter_core;

    // Sizes match the defaults the block is built with.
    localparam int ROW_LEN   = tgmc_pkg::ROW_LENGTH_DEF;
    localparam int KEY_SLOTS = tgmc_pkg::KEY_SLOTS_DEF;

    // The worst present entry searches the whole key table.
    // After the last summary the bench waits out DRAIN_CYCLES before it touches the
    // group limit, so that no search can still be running.
    localparam int DRAIN_CYCLES = 2 * KEY_SLOTS + 4;

    // The watchdog counts cycles with no transfer on either channel. The longest
    // correct quiet stretch is a drain, one full search and two idle bursts.
    localparam int IDLE_LIMIT = 4 * (DRAIN_CYCLES + 2 * KEY_SLOTS + 2 + 2 * 19);

    localparam int ITEM_TARGET = 1200;
    localparam int CALM_TAIL   = 150;
    localparam int POOL_MAX    = 8;

    // One row summary, as the output channel carries it.
    typedef struct packed {
        logic [tgmc_pkg::CNT_W-1:0]   transitions;
        logic [tgmc_pkg::CNT_W-1:0]   groups;
        logic [tgmc_pkg::SAVED_W-1:0] saved;
    } t_row_summary;

    // One directed entry. Where "typed" is set, the summary of the row that
    // this entry closes is given by hand instead of by the predictor.
    typedef struct packed {
        logic                         has;
        logic [tgmc_pkg::TGT_W-1:0]   tgt;
        logic [tgmc_pkg::MARK_W-1:0]  mark;
        logic                         last;
        logic                         typed;
        logic [tgmc_pkg::CNT_W-1:0]   transitions;
        logic [tgmc_pkg::CNT_W-1:0]   groups;
        logic [tgmc_pkg::SAVED_W-1:0] saved;
    } t_directed_entry;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [tgmc_pkg::LIMIT_W-1:0]   i_cfg_wdata;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic                           i_has_transition;
    logic [tgmc_pkg::TGT_W-1:0]     i_target_state;
    logic [tgmc_pkg::MARK_W-1:0]    i_marker_offset;
    logic                           i_row_end;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [tgmc_pkg::CNT_W-1:0]     o_transition_total;
    logic [tgmc_pkg::CNT_W-1:0]     o_group_total;
    logic [tgmc_pkg::SAVED_W-1:0]   o_rules_saved;

    transition_group_merge_counter_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_has_transition   (i_has_transition),
        .i_target_state     (i_target_state),
        .i_marker_offset    (i_marker_offset),
        .i_row_end          (i_row_end),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_transition_total (o_transition_total),
        .o_group_total      (o_group_total),
        .o_rules_saved      (o_rules_saved)
    );

    // ------------------------------------------------------------------------
    // Predictor state: the bench's own copy of the distinct-key table, the row
    // counters and the group limit.
    // ------------------------------------------------------------------------
    logic [tgmc_pkg::TGT_W-1:0]     seen_target [KEY_SLOTS];
    logic [tgmc_pkg::MARK_W-1:0]    seen_marker [KEY_SLOTS];
    int unsigned                    seen_fill   [KEY_SLOTS];
    int unsigned                    seen_keys;
    int unsigned                    row_present;
    int unsigned                    row_groups;
    logic [tgmc_pkg::LIMIT_W-1:0]   merge_limit;

    // Summaries owed by the block, oldest first.
    t_row_summary         row_summary_q [$];

    int                   error_count;
    int                   entries_sent;
    int                   present_sent;
    int                   rows_closed;
    int                   rows_capped;
    int                   summaries_checked;
    int                   limits_used;
    int                   idle_cycles;

    // Idling controls. calm_tail switches all idling off for the last part
    // of the run; the other two give stretches without idling per phase.
    bit                   gaps_on;
    bit                   stall_on;
    bit                   calm_tail;

    // Directed rows under the reset limit of 3. They cover an empty row after
    // reset, the all-ones key, a key that wraps its group, keys that differ
    // in both fields, an absent entry inside a row, and a row closed by an
    // absent entry.
    t_directed_entry directed_rows [18] = '{
        '{1'b0, 16'h0000, 32'h0000_0000, 1'b1, 1'b1, 9'd0, 9'd0, 8'd0},
        '{1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 9'd1, 9'd1, 8'd0},
        '{1'b1, 16'h0000, 32'h0000_0000, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
        '{1'b1, 16'h0000, 32'h0000_0000, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
        '{1'b1, 16'h0000, 32'h0000_0000, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
        '{1'b1, 16'h0000, 32'h0000_0000, 1'b1, 1'b1, 9'd4, 9'd2, 8'd2},
        '{1'b1, 16'h0001, 32'h0000_0000, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
        '{1'b1, 16'h0000, 32'h0000_0001, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
        '{1'b0, 16'h0001, 32'h0000_0000, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
        '{1'b1, 16'h0001, 32'h0000_0000, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
        '{1'b1, 16'h0000, 32'h0000_0001, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
        '{1'b1, 16'h0001, 32'h0000_0000, 1'b1, 1'b0, 9'd0, 9'd0, 8'd0},
        '{1'b1, 16'hA5A5, 32'h5A5A_5A5A, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
        '{1'b0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 9'd1, 9'd1, 8'd0},
        '{1'b1, 16'h5A5A, 32'hA5A5_A5A5, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
        '{1'b1, 16'h5A5A, 32'hA5A5_A5A5, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
        '{1'b1, 16'h5A5A, 32'hA5A5_A5A5, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
        '{1'b1, 16'h5A5A, 32'hA5A5_A5A5, 1'b1, 1'b0, 9'd0, 9'd0, 8'd0}
    };

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Every mismatch goes through here: one line, one count.
    task automatic note_error(input string what);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Predictor. Applies one accepted entry to the row and, when the entry
    // ends the row, hands back the summary and clears the row.
    // ------------------------------------------------------------------------
    task automatic tally_entry(input logic has, input logic [tgmc_pkg::TGT_W-1:0] tgt,
                               input logic [tgmc_pkg::MARK_W-1:0] mark, input logic last,
                               output bit closed, output t_row_summary summary);
        int unsigned span;
        int unsigned slot;
        bit          hit;
        bit          stored;

        // A limit of zero packs like a limit of one.
        span   = (merge_limit == '0) ? 1 : int'(merge_limit);
        closed = 1'b0;
        summary = '0;

        // Present entries beyond the row length are dropped without a trace.
        if (has && row_present < ROW_LEN) begin
            row_present++;
            hit  = 1'b0;
            slot = 0;
            while (!hit && slot < seen_keys && slot < KEY_SLOTS) begin
                if (seen_target[slot] == tgt && seen_marker[slot] == mark)
                    hit = 1'b1;
                else
                    slot++;
            end
            stored = hit;
            if (!hit && seen_keys < KEY_SLOTS) begin
                slot              = seen_keys;
                seen_target[slot] = tgt;
                seen_marker[slot] = mark;
                seen_fill[slot]   = 0;
                seen_keys++;
                stored = 1'b1;
            end
            if (!stored) begin
                // No room for the key: it stands as a group of its own.
                row_groups++;
            end else begin
                // A new group opens whenever the key's fill has wrapped.
                if (seen_fill[slot] == 0)
                    row_groups++;
                seen_fill[slot]++;
                if (seen_fill[slot] >= span)
                    seen_fill[slot] = 0;
            end
        end

        if (last) begin
            closed              = 1'b1;
            summary.transitions = row_present[tgmc_pkg::CNT_W-1:0];
            summary.groups      = row_groups[tgmc_pkg::CNT_W-1:0];
            summary.saved       = tgmc_pkg::SAVED_W'(row_present - row_groups);
            if (row_present >= ROW_LEN)
                rows_capped++;
            rows_closed++;
            seen_keys   = 0;
            row_present = 0;
            row_groups  = 0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Input side. Drives one entry at the falling edge, holds it until the
    // block takes it, then runs the predictor. A random burst of idle cycles
    // may come first. Valid is raised without looking at stall.
    // ------------------------------------------------------------------------
    task automatic send_entry(input logic has, input logic [tgmc_pkg::TGT_W-1:0] tgt,
                              input logic [tgmc_pkg::MARK_W-1:0] mark, input logic last,
                              input bit typed = 1'b0,
                              input t_row_summary typed_summary = '0);
        int           gap;
        bit           closed;
        t_row_summary summary;

        if (gaps_on && !calm_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end

        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_has_transition <= has;
        i_target_state   <= tgt;
        i_marker_offset  <= mark;
        i_row_end        <= last;

        // The transfer happens at the first rising edge with stall low.
        do @(posedge i_clk); while (o_in_stall);

        entries_sent++;
        if (has)
            present_sent++;
        if (entries_sent >= ITEM_TARGET - CALM_TAIL)
            calm_tail = 1'b1;

        tally_entry(has, tgt, mark, last, closed, summary);
        if (closed)
            row_summary_q.push_back(typed ? typed_summary : summary);
    endtask

    // Lowers valid, waits for every owed summary, then lets any search that
    // might still be running finish before the group limit is touched.
    task automatic settle_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (row_summary_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes the group limit register; only called while the block is idle.
    task automatic load_group_limit(input logic [tgmc_pkg::LIMIT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        merge_limit = value;
        limits_used++;
    endtask

    // ------------------------------------------------------------------------
    // One random row. Keys come from a small pool so that they repeat and
    // merge; pool keys often share their target or their marker with a
    // neighbor, so the equality check must look at both fields. Absent
    // entries are sprinkled in, and some rows end on an absent entry. Now and
    // then a short row uses a key from outside the pool.
    // ------------------------------------------------------------------------
    task automatic send_row(input int present_goal, input int absent_pct,
                            input int pool_size, input bit allow_stray);
        logic [tgmc_pkg::TGT_W-1:0]  pool_tgt  [POOL_MAX];
        logic [tgmc_pkg::MARK_W-1:0] pool_mark [POOL_MAX];
        int                          k;
        int                          sent;
        bit                          tail_absent;
        logic [tgmc_pkg::TGT_W-1:0]  tgt;
        logic [tgmc_pkg::MARK_W-1:0] mark;

        for (k = 0; k < pool_size; k++) begin
            pool_tgt[k]  = tgmc_pkg::TGT_W'($urandom);
            pool_mark[k] = $urandom;
            if (k > 0) begin
                case ($urandom_range(0, 3))
                    0: pool_tgt[k]  = pool_tgt[k-1];
                    1: pool_mark[k] = pool_mark[k-1];
                    default: ;
                endcase
            end
        end

        tail_absent = (present_goal == 0) || ($urandom_range(0, 3) == 0);
        sent = 0;
        while (sent < present_goal) begin
            if ($urandom_range(0, 99) < absent_pct) begin
                send_entry(1'b0, tgmc_pkg::TGT_W'($urandom), $urandom, 1'b0);
            end else begin
                sent++;
                k    = $urandom_range(0, pool_size - 1);
                tgt  = pool_tgt[k];
                mark = pool_mark[k];
                if (allow_stray && $urandom_range(0, 15) == 0) begin
                    tgt  = tgmc_pkg::TGT_W'($urandom);
                    mark = $urandom;
                end
                send_entry(1'b1, tgt, mark, !tail_absent && sent == present_goal);
            end
        end
        if (tail_absent)
            send_entry(1'b0, tgmc_pkg::TGT_W'($urandom), $urandom, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall bursts, off in the calm tail.
    // ------------------------------------------------------------------------
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_on && !calm_tail && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Each summary transfer is checked against the oldest owed summary.
    always @(posedge i_clk) begin
        t_row_summary want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            summaries_checked++;
            if (row_summary_q.size() == 0) begin
                note_error($sformatf("summary %0d arrived with none owed (%0d/%0d/%0d)",
                                     summaries_checked, o_transition_total,
                                     o_group_total, o_rules_saved));
            end else begin
                want = row_summary_q.pop_front();
                if (o_transition_total !== want.transitions)
                    note_error($sformatf("summary %0d: transition_total %0d, expected %0d",
                                         summaries_checked, o_transition_total,
                                         want.transitions));
                if (o_group_total !== want.groups)
                    note_error($sformatf("summary %0d: group_total %0d, expected %0d",
                                         summaries_checked, o_group_total, want.groups));
                if (o_rules_saved !== want.saved)
                    note_error($sformatf("summary %0d: rules_saved %0d, expected %0d",
                                         summaries_checked, o_rules_saved, want.saved));
            end
        end
    end

    // Watchdog: too long without any transfer means the block is hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d summaries still owed",
                     idle_cycles, row_summary_q.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [tgmc_pkg::LIMIT_W-1:0] limit_plan [7];
        logic [tgmc_pkg::LIMIT_W-1:0] limit;
        t_row_summary                 typed_summary;
        int                           phase;
        int                           rows_in_phase;

        // Extremes of the 9-bit register first, then limits of 2, 255 and 4.
        limit_plan = '{9'd1, 9'd0, 9'd256, 9'd511, 9'd2, 9'd255, 9'd4};

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        i_in_valid       = 1'b0;
        i_has_transition = 1'b0;
        i_target_state   = '0;
        i_marker_offset  = '0;
        i_row_end        = 1'b0;

        error_count       = 0;
        entries_sent      = 0;
        present_sent      = 0;
        rows_closed       = 0;
        rows_capped       = 0;
        summaries_checked = 0;
        limits_used       = 0;
        idle_cycles       = 0;
        seen_keys         = 0;
        row_present       = 0;
        row_groups        = 0;
        merge_limit       = tgmc_pkg::LIMIT_RESET;
        gaps_on           = 1'b1;
        stall_on          = 1'b1;
        calm_tail         = 1'b0;

        // Synchronous reset, held at the start and never asserted again.
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table under the reset limit.
        foreach (directed_rows[n]) begin
            typed_summary.transitions = directed_rows[n].transitions;
            typed_summary.groups      = directed_rows[n].groups;
            typed_summary.saved       = directed_rows[n].saved;
            send_entry(directed_rows[n].has, directed_rows[n].tgt, directed_rows[n].mark,
                       directed_rows[n].last, directed_rows[n].typed, typed_summary);
        end

        // Random phases. Each phase sets a new limit while the block is idle.
        // The phases with limits of 1 and 256 also carry a row longer than the
        // row length, built from very few keys, which reaches the largest
        // totals and the largest saving and exercises the dropped entries.
        phase = 0;
        while (entries_sent < ITEM_TARGET) begin
            settle_block();
            if (phase < $size(limit_plan))
                limit = limit_plan[phase];
            else if ($urandom_range(0, 3) == 0)
                limit = tgmc_pkg::LIMIT_W'($urandom_range(0, 511));
            else
                limit = tgmc_pkg::LIMIT_W'($urandom_range(1, 8));
            load_group_limit(limit);

            gaps_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);

            if (phase == 0 || phase == 2)
                send_row(ROW_LEN + $urandom_range(1, 10), 3, $urandom_range(1, 3), 1'b0);

            rows_in_phase = $urandom_range(6, 14);
            repeat (rows_in_phase) begin
                case ($urandom_range(0, 7))
                    0:       send_row($urandom_range(0, 2), 60, 1, 1'b1);
                    1:       send_row($urandom_range(8, 24), 10, $urandom_range(1, 2), 1'b0);
                    default: send_row($urandom_range(1, 12), 20,
                                      $urandom_range(1, 6), 1'b1);
                endcase
            end
            phase++;
        end

        // Wait for every owed summary and let the block fall quiet.
        settle_block();
        if (row_summary_q.size() != 0)
            note_error($sformatf("%0d summaries never arrived", row_summary_q.size()));

        $display("Sent %0d entries (%0d with a transition) in %0d rows under %0d limit writes.",
                 entries_sent, present_sent, rows_closed, limits_used);
        $display("Checked %0d row summaries; %0d rows reached the row length cap.",
                 summaries_checked, rows_capped);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
